// ----- rtl/core/stlt_pkg.sv -----
// ----------------------------------------------------------------------------
// stlt_pkg
// Shared types and constants for the smoothed step limited 3D tracker.
// ----------------------------------------------------------------------------
package stlt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int SF_W       = 17;
  localparam int MS_W       = 31;
  localparam int FRAC_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd1;

  localparam logic [SF_W-1:0] SF_RESET = 17'd26214;
  localparam logic [SF_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic [MS_W-1:0] MS_RESET = 31'd589824;

  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               was_clamped;
  } out_word_t;

endpackage

// ----- rtl/core/stlt_front.sv -----
// ----------------------------------------------------------------------------
// stlt_front
// Accepts input words, classifies load vs. step, converts coordinates and
// queues them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module stlt_front #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stlt_pkg::in_word_t   in_word,
  output logic                 q_valid,
  output logic [3*CW:0]        q_data,
  input  logic                 q_pop
);

  localparam int QW    = 3 * CW + 1;
  localparam int DEPTH = 2;

  logic [QW-1:0] mem_r [DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic [63:0]   ex, ey, ez;
  logic [QW-1:0] entry;

  // low CW bits of the zero-extended field: truncates or zero-extends
  assign ex = {32'b0, in_word.target_x};
  assign ey = {32'b0, in_word.target_y};
  assign ez = {32'b0, in_word.target_z};
  assign entry = {(in_word.action == stlt_pkg::ACT_LOAD), ex[CW-1:0], ey[CW-1:0], ez[CW-1:0]};

  assign in_stall = (cnt_r == 2'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ----- rtl/core/stlt_back.sv -----
// ----------------------------------------------------------------------------
// stlt_back
// Sequencer for one queued word; a step runs smoothing multiply, range
// normalize, sum of squares, bitwise square root, clamp divide, saturating add.
// ----------------------------------------------------------------------------
module stlt_back #(
  parameter int CW = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [stlt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stlt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                q_valid,
  input  logic [3*CW:0]                       q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output stlt_pkg::out_word_t                 out_word
);

  localparam int MW = CW + 1;
  localparam int WW = (MW > 32) ? MW : 32;
  localparam int PW = MW + stlt_pkg::SF_W;
  localparam int AW = (MW > 31) ? MW : 31;
  localparam int SW = AW + 2;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_NORM = 10'b0000000100,
    S_SQ   = 10'b0000001000,
    S_SQRT = 10'b0000010000,
    S_CMP  = 10'b0000100000,
    S_PROD = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_ADD  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [stlt_pkg::SF_W-1:0] sf_r, sf_nxt, sf_eff;
  logic [stlt_pkg::MS_W-1:0] ms_r, ms_nxt;
  logic signed [CW-1:0]   pos_r [3];
  logic signed [CW-1:0]   pos_nxt [3];
  logic [MW-1:0]          ad_r [3];
  logic [MW-1:0]          ad_nxt [3];
  logic [MW-1:0]          c_r [3];
  logic [MW-1:0]          c_nxt [3];
  logic [2:0]             neg_r, neg_nxt;
  logic                   sflag_r, sflag_nxt;
  logic                   clamp_r, clamp_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic [61:0]            prod_r, prod_nxt;
  logic [63:0]            sum_r, sum_nxt;
  logic [33:0]            rem_r, rem_nxt;
  logic [31:0]            root_r, root_nxt;
  logic [31:0]            drem_r [3];
  logic [31:0]            drem_nxt [3];
  logic [30:0]            dq_r [3];
  logic [30:0]            dq_nxt [3];
  logic                   out_valid_r, out_valid_nxt;
  stlt_pkg::out_word_t    out_word_r, out_word_nxt;

  logic signed [CW-1:0]   tgt [3];
  logic signed [CW:0]     dif [3];
  logic [PW-1:0]          mulp [3];
  logic [WW-1:0]          wide [3];
  logic [30:0]            c31 [3];
  logic                   big;
  logic [30:0]            mul_a, mul_b;
  logic [61:0]            mul_out;
  logic [35:0]            trial, test;
  logic [32:0]            rem2 [3];
  logic [32:0]            rdif [3];
  logic [2:0]             ge;
  logic [AW-1:0]          mag [3];
  logic signed [SW-1:0]   pe [3];
  logic signed [SW-1:0]   me [3];
  logic signed [SW-1:0]   rs [3];
  logic signed [SW-1:0]   hi, lo;
  logic [63:0]            o64 [3];
  logic                   out_free;

  assign tgt[0] = q_data[3*CW-1:2*CW];
  assign tgt[1] = q_data[2*CW-1:CW];
  assign tgt[2] = q_data[CW-1:0];

  assign sf_eff   = (sf_r > stlt_pkg::GAIN_ONE) ? stlt_pkg::GAIN_ONE : sf_r;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign hi       = SW'({1'b0, {(CW-1){1'b1}}});
  assign lo       = ~hi;

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dif[i]  = {tgt[i][CW-1], tgt[i]} - {pos_r[i][CW-1], pos_r[i]};
      mulp[i] = PW'(ad_r[i]) * PW'(sf_eff);
      wide[i] = WW'(c_r[i]);
      c31[i]  = wide[i][30:0];
      big     = big | (wide[i][WW-1:31] != '0);
      rem2[i] = {drem_r[i], dq_r[i][30]};
      rdif[i] = rem2[i] - {1'b0, root_r};
      ge[i]   = (rem2[i] >= {1'b0, root_r});
      mag[i]  = clamp_r ? AW'(dq_r[i]) : AW'(c_r[i]);
      pe[i]   = SW'(pos_r[i]);
      me[i]   = SW'({2'b00, mag[i]});
      rs[i]   = neg_r[i] ? (pe[i] - me[i]) : (pe[i] + me[i]);
      o64[i]  = {{(64-CW){1'b0}}, pos_r[i]};
    end
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mul_a = c31[0];
      2'd1:    mul_a = c31[1];
      default: mul_a = c31[2];
    endcase
    mul_b   = (state_r == S_SQ) ? mul_a : ms_r;
    mul_out = {31'b0, mul_a} * {31'b0, mul_b};
    trial   = {rem_r, sum_r[63:62]};
    test    = {2'b00, root_r, 2'b01};
  end

  always_comb begin
    state_nxt     = state_r;
    sf_nxt        = sf_r;
    ms_nxt        = ms_r;
    pos_nxt       = pos_r;
    ad_nxt        = ad_r;
    c_nxt         = c_r;
    neg_nxt       = neg_r;
    sflag_nxt     = sflag_r;
    clamp_nxt     = clamp_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    drem_nxt      = drem_r;
    dq_nxt        = dq_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (cfg_we) begin
      case (cfg_index)
        stlt_pkg::CFG_SMOOTH:   sf_nxt = cfg_wdata[stlt_pkg::SF_W-1:0];
        stlt_pkg::CFG_MAX_STEP: ms_nxt = cfg_wdata[stlt_pkg::MS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_data[3*CW] == stlt_pkg::ACT_LOAD) begin
            pos_nxt   = tgt;
            clamp_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              neg_nxt[i] = dif[i][CW];
              ad_nxt[i]  = dif[i][CW] ? MW'(-dif[i]) : MW'(dif[i]);
            end
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        for (int i = 0; i < 3; i++) begin
          c_nxt[i] = mulp[i][MW+stlt_pkg::FRAC_BITS-1:stlt_pkg::FRAC_BITS];
        end
        sflag_nxt = 1'b0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            c_nxt[i] = c_r[i] >> 1;
          end
          sflag_nxt = 1'b1;
        end else begin
          cnt_nxt   = 5'd0;
          sum_nxt   = 64'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        prod_nxt = mul_out;
        if (cnt_r != 5'd0) begin
          sum_nxt = sum_r + 64'(prod_r);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          rem_nxt   = 34'd0;
          root_nxt  = 32'd0;
          cnt_nxt   = 5'd0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (trial >= test) begin
          rem_nxt  = 34'(trial - test);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = trial[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        sum_nxt = sum_r << 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        clamp_nxt = sflag_r || (root_r > {1'b0, ms_r});
        cnt_nxt   = 5'd0;
        state_nxt = (sflag_r || (root_r > {1'b0, ms_r})) ? S_PROD : S_ADD;
      end
      S_PROD: begin
        for (int i = 0; i < 3; i++) begin
          if (cnt_r[1:0] == 2'(i)) begin
            drem_nxt[i] = {1'b0, mul_out[61:31]};
            dq_nxt[i]   = mul_out[30:0];
          end
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = 5'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          drem_nxt[i] = ge[i] ? rdif[i][31:0] : rem2[i][31:0];
          dq_nxt[i]   = {dq_r[i][29:0], ge[i]};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 3; i++) begin
          if (rs[i] > hi) begin
            pos_nxt[i] = hi[CW-1:0];
          end else if (rs[i] < lo) begin
            pos_nxt[i] = lo[CW-1:0];
          end else begin
            pos_nxt[i] = rs[i][CW-1:0];
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.new_x       = o64[0][31:0];
          out_word_nxt.new_y       = o64[1][31:0];
          out_word_nxt.new_z       = o64[2][31:0];
          out_word_nxt.was_clamped = clamp_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sf_r        <= stlt_pkg::SF_RESET;
      ms_r        <= stlt_pkg::MS_RESET;
      pos_r       <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sf_r        <= sf_nxt;
      ms_r        <= ms_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ad_r       <= ad_nxt;
    c_r        <= c_nxt;
    neg_r      <= neg_nxt;
    sflag_r    <= sflag_nxt;
    clamp_r    <= clamp_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    drem_r     <= drem_nxt;
    dq_r       <= dq_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_MUL || state_r == S_DONE))
    else $error("queue pop did not start a word");

  a_clamp_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROD && !sflag_r) |-> (root_r > {1'b0, ms_r}))
    else $error("clamp without length above limit");

  a_quo_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && clamp_r) |->
      (dq_r[0] <= ms_r && dq_r[1] <= ms_r && dq_r[2] <= ms_r))
    else $error("scaled step above limit");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished word not presented");

endmodule

// ----- rtl/core/smoothed_step_limited_tracker_3d_core.sv -----
// ----------------------------------------------------------------------------
// smoothed_step_limited_tracker_3d_core
// Tracks a 3D position: smoothed, length-limited steps toward targets.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : input words (action, target point). action load sets the
//           position; action step moves toward the target by the smoothing
//           gain, limited in length to the step limit register.
//   out_* : one result word per input word, the new position and a flag
//           telling whether the step was scaled down.
//   cfg_* : register writes (smoothing gain, step limit), only while idle.
// Sequence: a load goes from idle straight to the output stage; a step runs
//   a one-bit-per-cycle range normalize, a bitwise square root and, when
//   clamped, a divide (three lanes in parallel), then the saturating add.
// Flow: words are processed one at a time by the back end sequencer; a
//   two-word queue in front keeps accepting while it works, until it is full.
// Reset: position goes to zero, registers to their defaults, queue empties.
// Stall: a result waits in the output register; the back end finishes the
//   next word and holds it until the output register frees up.
// ----------------------------------------------------------------------------
module smoothed_step_limited_tracker_3d_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  stlt_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output stlt_pkg::out_word_t              out_word,
  input  logic                             cfg_we,
  input  logic [stlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stlt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                   q_valid;
  logic                   q_pop;
  logic [3*COORD_WIDTH:0] q_data;

  stlt_front #(.CW(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  stlt_back #(.CW(COORD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
